// ===== hw/rtl/rtdo_pkg.sv =====
package rtdo_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned GenW     = 32;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned PixW     = 10;

  localparam logic [GenW-1:0] Multiplier = 32'd3538123;

  localparam int unsigned   TriesW       = 16;
  localparam logic [TriesW-1:0] MaxTriesLast = 16'hFFFF;

  localparam logic [5:0]  GridWidthRst  = 6'd18;
  localparam logic [4:0]  GridHeightRst = 5'd6;
  localparam logic [8:0]  OriginXRst    = 9'd80;
  localparam logic [7:0]  OriginYRst    = 8'd88;
  localparam logic [31:0] SeedRst       = 32'd9;

  localparam int unsigned DivW      = 32;
  localparam int unsigned DvsW      = 6;
  localparam int unsigned DivStep   = 4;
  localparam int unsigned DivCycles = DivW / DivStep;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_ORIGIN_X    = 3'd2,
    REG_ORIGIN_Y    = 3'd3,
    REG_SEED        = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SWEEP,
    OP_ARM,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_SCAN_TAKE,
    OP_GEN,
    OP_DIV_X,
    OP_DIV_Y,
    OP_DIV_FB,
    OP_TAKE_X,
    OP_TAKE_Y,
    OP_TAKE_FB,
    OP_IDX,
    OP_IDX_RD,
    OP_MISS,
    OP_COMMIT,
    OP_NONE,
    OP_PUSH
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ARM,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_GEN_X,
    ST_DIV_X,
    ST_WAIT_X,
    ST_GEN_Y,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_IDX,
    ST_RD,
    ST_TEST,
    ST_FB_DIV,
    ST_FB_WAIT,
    ST_COMMIT,
    ST_NONE,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic rem_zero;
    logic fast_any;
    logic limit_zero;
    logic ptr_last;
    logic scan_end;
    logic mem_hit;
    logic draw_hit;
    logic tries_last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/rtdo_divider.sv =====
module rtdo_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rtdo_pkg::DivW-1:0] dividend_i,
  input  logic [rtdo_pkg::DvsW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [rtdo_pkg::DvsW-1:0] rem_o,
  output logic [rtdo_pkg::DivW-1:0] quo_o
);
  import rtdo_pkg::*;

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsW-1:0]    dvs_q;
  logic [DvsW:0]      trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < DivStep; k++) begin
      trial = {rem_d, quo_d[DivW-1]};
      quo_d = {quo_d[DivW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DvsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivCycles - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/rtdo_datapath.sv =====
module rtdo_datapath #(
  parameter int unsigned MAX_CELLS = 128,
  parameter int unsigned TILE_SIZE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtdo_pkg::dp_op_e              op_i,
  output rtdo_pkg::status_t             status_o,
  input  logic                          cfg_we_i,
  input  logic [rtdo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtdo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [rtdo_pkg::OutDataW-1:0] m_data_o,
  output logic                          m_last_o,
  output logic                          m_none_o
);
  import rtdo_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);

  logic [5:0]       grid_w_q;
  logic [4:0]       grid_h_q;
  logic [8:0]       org_x_q;
  logic [7:0]       org_y_q;
  logic [GenW-1:0]  gen_q, gen_d;
  logic [GenW-1:0]  prod_q, prod_d;
  logic [CW-1:0]    limit_q, limit_d, rlimit_q, cells_q;
  logic [AW-1:0]    ptr_q;
  logic [TriesW-1:0] tries_q;
  logic [5:0]       x_q;
  logic [PixW-1:0]  y_q;
  logic [IdxW-1:0]  idx_q, total;
  logic             rd_q;
  logic             res_last_q, res_none_q;
  logic             out_valid_q, out_last_q, out_none_q;
  logic [OutDataW-1:0] out_data_q, pack_data;

  logic             pend_mem [MAX_CELLS];
  logic             mem_we, mem_re, mem_wdata;
  logic [AW-1:0]    mem_waddr, mem_raddr;

  logic             div_start, div_busy;
  logic [DivW-1:0]  div_dividend, div_quo;
  logic [DvsW-1:0]  div_divisor, div_rem;

  logic [15:0]      prod_px;
  logic [19:0]      prod_py;
  logic [PixW-1:0]  pix_x, pix_y;

  function automatic logic [GenW-1:0] xorshift(input logic [GenW-1:0] g);
    logic [GenW-1:0] t;
    t = g ^ (g >> 6);
    t = t ^ (t << 11);
    t = t ^ (t >> 15);
    return t;
  endfunction

  assign gen_d   = xorshift(gen_q);
  assign prod_d  = gen_d * Multiplier;
  assign total   = IdxW'(grid_w_q) * IdxW'(grid_h_q);
  assign limit_d = (total < IdxW'(MAX_CELLS)) ? CW'(total) : CW'(MAX_CELLS);

  // configuration, generator and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GridWidthRst;
      grid_h_q <= GridHeightRst;
      org_x_q  <= OriginXRst;
      org_y_q  <= OriginYRst;
      gen_q    <= SeedRst;
      limit_q  <= '0;
      rlimit_q <= '0;
      cells_q  <= '0;
      ptr_q    <= '0;
      tries_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_GRID_WIDTH:  grid_w_q <= cfg_data_i[5:0];
          REG_GRID_HEIGHT: grid_h_q <= cfg_data_i[4:0];
          REG_ORIGIN_X:    org_x_q  <= cfg_data_i[8:0];
          REG_ORIGIN_Y:    org_y_q  <= cfg_data_i[7:0];
          REG_SEED:        gen_q    <= cfg_data_i;
          default: ;
        endcase
      end
      case (op_i)
        OP_LOAD: begin
          limit_q <= limit_d;
          ptr_q   <= '0;
          tries_q <= '0;
        end
        OP_SWEEP, OP_SCAN_NEXT: ptr_q <= ptr_q + AW'(1);
        OP_ARM: begin
          cells_q  <= limit_q;
          rlimit_q <= limit_q;
          ptr_q    <= '0;
        end
        OP_GEN: gen_q <= gen_d;
        OP_MISS: begin
          tries_q <= tries_q + TriesW'(1);
          ptr_q   <= '0;
        end
        OP_COMMIT: begin
          if (cells_q != '0) begin
            cells_q <= cells_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // drawn cell and result flags
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_GEN:       prod_q <= prod_d;
      OP_TAKE_X:    x_q    <= div_rem;
      OP_TAKE_Y:    y_q    <= PixW'(div_rem);
      OP_TAKE_FB: begin
        x_q <= div_rem;
        y_q <= div_quo[PixW-1:0];
      end
      OP_IDX:       idx_q  <= IdxW'(x_q) + IdxW'(y_q[4:0]) * IdxW'(grid_w_q);
      OP_SCAN_TAKE: idx_q  <= IdxW'(ptr_q);
      OP_COMMIT: begin
        res_last_q <= (cells_q <= CW'(1));
        res_none_q <= 1'b0;
      end
      OP_NONE: begin
        res_last_q <= 1'b0;
        res_none_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // pending flags
  assign mem_we    = (op_i == OP_SWEEP) || (op_i == OP_COMMIT);
  assign mem_re    = (op_i == OP_SCAN_RD) || (op_i == OP_IDX_RD);
  assign mem_waddr = (op_i == OP_SWEEP) ? ptr_q : idx_q[AW-1:0];
  assign mem_wdata = (op_i == OP_SWEEP) ? (CW'(ptr_q) < limit_q) : 1'b0;
  assign mem_raddr = (op_i == OP_SCAN_RD) ? ptr_q : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= pend_mem[mem_raddr];
    end
  end

  assign div_start    = (op_i == OP_DIV_X) || (op_i == OP_DIV_Y) || (op_i == OP_DIV_FB);
  assign div_dividend = (op_i == OP_DIV_FB) ? DivW'(idx_q) : prod_q;
  assign div_divisor  = (op_i == OP_DIV_Y) ? {1'b0, grid_h_q} : grid_w_q;

  rtdo_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  assign prod_px   = 16'(x_q) * 16'(TILE_SIZE);
  assign prod_py   = 20'(y_q) * 20'(TILE_SIZE);
  assign pix_x     = PixW'(org_x_q) + prod_px[PixW-1:0];
  assign pix_y     = PixW'(org_y_q) + prod_py[PixW-1:0];
  assign pack_data = {4'b0, pix_y, pix_x, idx_q[6:0], y_q[3:0], x_q[4:0]};

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PUSH) begin
      out_data_q <= res_none_q ? '0 : pack_data;
      out_last_q <= res_last_q;
      out_none_q <= res_none_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;
  assign m_none_o  = out_none_q;

  assign status_o.rem_zero   = (cells_q == '0);
  assign status_o.fast_any   = (limit_q >= rlimit_q);
  assign status_o.limit_zero = (limit_q == '0);
  assign status_o.ptr_last   = (ptr_q == AW'(MAX_CELLS - 1));
  assign status_o.scan_end   = (CW'(ptr_q) == limit_q - CW'(1));
  assign status_o.mem_hit    = rd_q;
  assign status_o.draw_hit   = (idx_q < IdxW'(MAX_CELLS)) && rd_q;
  assign status_o.tries_last = (tries_q == MaxTriesLast);
  assign status_o.div_busy   = div_busy;
  assign status_o.out_free   = !out_valid_q || m_ready_i;

endmodule

// ===== hw/rtl/rtdo_ctrl.sv =====
module rtdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              restart_i,
  input  rtdo_pkg::status_t status_i,
  output logic              s_ready_o,
  output rtdo_pkg::dp_op_e  op_o
);
  import rtdo_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        fb_q, fb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fb_q    <= fb_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    fb_d      = fb_q;
    op_o      = OP_IDLE;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          op_o    = OP_LOAD;
          fb_d    = 1'b0;
          state_d = restart_i ? ST_SWEEP : ST_CHECK;
        end
      end
      ST_SWEEP: begin
        op_o = OP_SWEEP;
        if (status_i.ptr_last) begin
          state_d = ST_ARM;
        end
      end
      ST_ARM: begin
        op_o    = OP_ARM;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.rem_zero) begin
          state_d = ST_NONE;
        end else if (status_i.fast_any) begin
          state_d = ST_GEN_X;
        end else if (status_i.limit_zero) begin
          state_d = ST_NONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        op_o    = OP_SCAN_RD;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (status_i.mem_hit) begin
          if (fb_q) begin
            op_o    = OP_SCAN_TAKE;
            state_d = ST_FB_DIV;
          end else begin
            state_d = ST_GEN_X;
          end
        end else if (status_i.scan_end) begin
          state_d = ST_NONE;
        end else begin
          op_o    = OP_SCAN_NEXT;
          state_d = ST_SCAN_RD;
        end
      end
      ST_GEN_X: begin
        op_o    = OP_GEN;
        state_d = ST_DIV_X;
      end
      ST_DIV_X: begin
        op_o    = OP_DIV_X;
        state_d = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (!status_i.div_busy) begin
          op_o    = OP_TAKE_X;
          state_d = ST_GEN_Y;
        end
      end
      ST_GEN_Y: begin
        op_o    = OP_GEN;
        state_d = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        op_o    = OP_DIV_Y;
        state_d = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (!status_i.div_busy) begin
          op_o    = OP_TAKE_Y;
          state_d = ST_IDX;
        end
      end
      ST_IDX: begin
        op_o    = OP_IDX;
        state_d = ST_RD;
      end
      ST_RD: begin
        op_o    = OP_IDX_RD;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.draw_hit) begin
          state_d = ST_COMMIT;
        end else begin
          op_o = OP_MISS;
          if (status_i.tries_last) begin
            fb_d    = 1'b1;
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_GEN_X;
          end
        end
      end
      ST_FB_DIV: begin
        op_o    = OP_DIV_FB;
        state_d = ST_FB_WAIT;
      end
      ST_FB_WAIT: begin
        if (!status_i.div_busy) begin
          op_o    = OP_TAKE_FB;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        op_o    = OP_COMMIT;
        state_d = ST_PUSH;
      end
      ST_NONE: begin
        op_o    = OP_NONE;
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (status_i.out_free) begin
          op_o    = OP_PUSH;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/random_tile_dissolve_order.sv =====
// Random tile dissolve order: each input beat requests the next cell of the
// tile grid that has not been shown yet, in pseudo-random order.
// Input beat: s_axis_tdata[0] = restart; a set restart first marks every cell
// below min(width*height, MAX_CELLS) pending again.
// Output beat: one per input beat. tlast marks the cell that completes the
// picture; tuser marks that no pending cell was left (tdata is then zero).
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while idle, which the block itself does not enforce.
// A seed write also reloads the generator.
// A restart sweeps all MAX_CELLS pending flags; after the grid shrank, the
// flags are checked one by one. Each drawn cell pair takes two generator
// steps, two remainder passes through the shared divider (4 bits a cycle),
// the index and one pending-flag read. Near completion the number of pairs
// grows toward the number of cells; after 65536 rejected pairs a
// lowest-index scan takes over. One item at a time; the next request is
// taken while the previous result still waits in the output register.
// Reset loads the register defaults and the seed, and leaves nothing
// pending. A stalled receiver holds the result; the block finishes the next
// item and then waits for the output register to empty.
module random_tile_dissolve_order #(
  parameter int unsigned MAX_CELLS = 128,
  parameter int unsigned TILE_SIZE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtdo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtdo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // restart
  input  logic [rtdo_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // cell_x, cell_y, cell_index, pixel_x, pixel_y
  output logic [rtdo_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // none_left
  output logic                          m_axis_tuser
);
  import rtdo_pkg::*;

  dp_op_e  op;
  status_t status;

  rtdo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .restart_i (s_axis_tdata[0]),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .op_o      (op)
  );

  rtdo_datapath #(
    .MAX_CELLS (MAX_CELLS),
    .TILE_SIZE (TILE_SIZE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_none_o   (m_axis_tuser)
  );

endmodule

// ===== test/tb_random_tile_dissolve_order.sv =====
`timescale 1ns / 1ps

module tb_random_tile_dissolve_order;
  import rtdo_pkg::*;

  localparam int unsigned MaxCells = 128;
  localparam int unsigned TileSize = 8;
  localparam int unsigned MaxTries = 65536;

  typedef struct {
    logic [4:0] col;
    logic [3:0] row;
    logic [6:0] idx;
    logic [9:0] pix_x;
    logic [9:0] pix_y;
    logic       fin;
    logic       empty_flag;
  } tile_pick_t;

  class dissolve_board;
    int unsigned width;
    int unsigned height;
    int unsigned org_x;
    int unsigned org_y;
    logic [31:0] gen;
    bit          pend [MaxCells];
    int unsigned cells_left;
    tile_pick_t  due [$];
    int unsigned faults;

    function new();
      width      = 32'(GridWidthRst);
      height     = 32'(GridHeightRst);
      org_x      = 32'(OriginXRst);
      org_y      = 32'(OriginYRst);
      gen        = SeedRst;
      cells_left = 0;
      faults     = 0;
      foreach (pend[i]) pend[i] = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [31:0] v);
      case (r)
        REG_GRID_WIDTH:  width  = 32'(v[5:0]);
        REG_GRID_HEIGHT: height = 32'(v[4:0]);
        REG_ORIGIN_X:    org_x  = 32'(v[8:0]);
        REG_ORIGIN_Y:    org_y  = 32'(v[7:0]);
        REG_SEED:        gen    = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] advance();
      logic [31:0] g;
      g = gen;
      g ^= g >> 6;
      g ^= g << 11;
      g ^= g >> 15;
      gen = g;
      return g * Multiplier;
    endfunction

    function void note_request(bit restart);
      int unsigned total, lim, x, y, ix, tries;
      bit any, found;
      tile_pick_t c;
      total = width * height;
      lim   = (total < MaxCells) ? total : MaxCells;
      c     = '{default: '0};
      if (restart) begin
        foreach (pend[i]) pend[i] = (i < lim);
        cells_left = lim;
      end
      any = 1'b0;
      for (int i = 0; i < lim; i++) if (pend[i]) any = 1'b1;
      if (!any) begin
        c.empty_flag = 1'b1;
      end else begin
        found = 1'b0;
        x = 0;
        y = 0;
        ix = 0;
        for (tries = 0; tries < MaxTries && !found; tries++) begin
          x  = advance() % width;
          y  = advance() % height;
          ix = x + y * width;
          if (ix < MaxCells && pend[ix]) found = 1'b1;
        end
        if (!found) begin
          for (int i = lim - 1; i >= 0; i--) if (pend[i]) ix = i;
          x = ix % width;
          y = ix / width;
        end
        pend[ix] = 1'b0;
        if (cells_left > 0) cells_left--;
        c.col   = x[4:0];
        c.row   = y[3:0];
        c.idx   = ix[6:0];
        c.pix_x = 10'(org_x + x * TileSize);
        c.pix_y = 10'(org_y + y * TileSize);
        c.fin   = (cells_left == 0);
      end
      due.push_back(c);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        faults++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_cell(logic [OutDataW-1:0] data, logic lst, logic usr);
      tile_pick_t c;
      if (due.size() == 0) begin
        faults++;
        $display("%0t ns: unexpected beat, expected none, got tdata %h", $time, data);
        return;
      end
      c = due.pop_front();
      compare("cell_x", 32'(c.col), 32'(data[4:0]));
      compare("cell_y", 32'(c.row), 32'(data[8:5]));
      compare("cell_index", 32'(c.idx), 32'(data[15:9]));
      compare("pixel_x", 32'(c.pix_x), 32'(data[25:16]));
      compare("pixel_y", 32'(c.pix_y), 32'(data[35:26]));
      compare("pad", 32'(0), 32'(data[OutDataW-1:36]));
      compare("last", 32'(c.fin), 32'(lst));
      compare("none_left", 32'(c.empty_flag), 32'(usr));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  dissolve_board board;
  bit            gaps_on  = 1'b1;
  bit            park_req = 1'b0;

  random_tile_dissolve_order #(
    .MAX_CELLS(MaxCells),
    .TILE_SIZE(TileSize)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_request(bit restart);
    s_axis_tdata  <= InDataW'(restart);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(restart);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_grid(logic [31:0] w, logic [31:0] h, logic [31:0] ox,
                              logic [31:0] oy, logic [31:0] sd);
    cfg_reg_e    regs [5];
    logic [31:0] vals [5];
    regs = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_ORIGIN_X, REG_ORIGIN_Y, REG_SEED};
    vals = '{w, h, ox, oy, sd};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      board.set_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned items);
    bit restart;
    for (int n = 0; n < items; n++) begin
      if (board.cells_left == 0) restart = ($urandom_range(0, 3) != 0);
      else restart = ($urandom_range(0, 29) == 0);
      send_request(restart);
    end
  endtask

  initial begin : drain
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_cell(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (park_req) begin
        park_req  = 1'b0;
        hold_left = 400;
      end else if (hold_left == 0 && gaps_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #200_000_000;
    $display("** random_tile_dissolve_order: FAILED **");
    $finish;
  end

  initial begin : main
    int unsigned w, h, ox, oy;
    logic [31:0] sd;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing pending after reset
    send_request(1'b0);
    settle();
    // default grid
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    settle();
    // single cell
    program_grid(1, 1, 0, 0, 32'h1234_5678);
    send_request(1'b1);
    send_request(1'b0);
    settle();
    // largest grid, origins at top of range
    program_grid(32, 16, 319, 239, 32'hFFFF_FFFF);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    settle();
    // shrink the grid under pending cells
    program_grid(8, 8, 17, 3, $urandom | 32'h1);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    settle();
    program_grid(2, 1, 200, 100, $urandom | 32'h1);
    repeat (3) send_request(1'b0);
    settle();
    // zero-sized grids
    program_grid(0, 4, 5, 5, 32'h55);
    send_request(1'b1);
    settle();
    program_grid(3, 0, 5, 5, 32'h77);
    send_request(1'b1);
    settle();
    // stuck generator: second pick falls back to lowest pending index
    program_grid(2, 1, 40, 40, 32'h0);
    send_request(1'b1);
    send_request(1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      gaps_on = (p != 2 && p != 5 && p != 7);
      w  = $urandom_range(1, 12);
      h  = $urandom_range(1, 8);
      ox = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 319);
      oy = ($urandom_range(0, 3) == 0) ? 239 : $urandom_range(0, 239);
      sd = $urandom;
      if (sd == 0) sd = 32'h1;
      if (p == 3) begin
        w  = 32;
        h  = 16;
        ox = 319;
        oy = 239;
      end else if (p == 6) begin
        w  = 1;
        h  = 1;
        ox = 0;
        oy = 0;
      end
      program_grid(w, h, ox, oy, sd);
      if (p == 1) park_req = 1'b1;
      run_phase(54);
      settle();
    end

    repeat (50) @(posedge clk_i);
    if (board.faults == 0 && board.due.size() == 0)
      $display("** random_tile_dissolve_order: PASSED **");
    else
      $display("** random_tile_dissolve_order: FAILED **");
    $finish;
  end

endmodule
